@@ rtl/lpai_pkg.sv @@
// ----------------------------------------------------------------------------
// lpai_pkg: shared constants and types for the log-polar angle index block
// Commands, register indexes, sector rule kinds and the arctangent table.
// ----------------------------------------------------------------------------
package lpai_pkg;

	localparam int DEF_MAX_RINGS   = 256;
	localparam int DEF_MAX_SECTORS = 256;
	localparam int DEF_MAX_FOVEA   = 64;
	localparam int DEF_ANGLE_BITS  = 16;

	localparam int CORDIC_STEPS = 28;
	localparam int CW           = 44;
	localparam int PAD_DEPTH    = 16384;
	localparam int PAD_AW       = 14;
	localparam int DIV_W        = 16;
	localparam int CFG_AW       = 2;
	localparam int CFG_DW       = 9;

	localparam logic [1:0] CMD_CALC  = 2'd0;
	localparam logic [1:0] CMD_SHIFT = 2'd1;
	localparam logic [1:0] CMD_PAD   = 2'd2;

	localparam logic [CFG_AW-1:0] REG_SECTORS = 2'd0;
	localparam logic [CFG_AW-1:0] REG_FOVEA   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MODE    = 2'd2;

	localparam logic [1:0] MODE_PAD  = 2'd0;
	localparam logic [1:0] MODE_GROW = 2'd1;

	typedef enum logic [1:0] {
		K_UNI,
		K_GROW,
		K_PAD
	} kind_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  ring;
		logic [13:0] addr;
		logic [15:0] data;
	} side_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

endpackage

@@ rtl/lpai_req_if.sv @@
// ----------------------------------------------------------------------------
// lpai_req_if: input word channel
// Valid/ready channel carrying one command word with point and table fields.
// ----------------------------------------------------------------------------
interface lpai_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] x_pos;
	logic signed [15:0] y_pos;
	logic [7:0]         ring;
	logic [13:0]        table_addr;
	logic [15:0]        table_data;

	modport source (output valid, cmd, x_pos, y_pos, ring, table_addr, table_data,
		input ready);
	modport sink (input valid, cmd, x_pos, y_pos, ring, table_addr, table_data,
		output ready);
endinterface

@@ rtl/lpai_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lpai_rsp_if: result word channel
// Valid/ready channel carrying the sector index and the range error flag.
// ----------------------------------------------------------------------------
interface lpai_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] sector;
	logic       range_error;

	modport source (output valid, sector, range_error, input ready);
	modport sink (input valid, sector, range_error, output ready);
endinterface

@@ rtl/lpai_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lpai_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lpai_cfg_if import lpai_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/lpai_cordic.sv @@
// ----------------------------------------------------------------------------
// lpai_cordic: pipelined vectoring CORDIC giving the angle as a turn fraction
// One iteration per stage; axis points and the origin bypass the iterations.
// ----------------------------------------------------------------------------
module lpai_cordic import lpai_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  side_t              in_side,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	output logic               out_vld,
	output side_t              out_side,
	output logic [31:0]        out_z
);

	logic signed [CW-1:0] cx_s    [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s    [0:CORDIC_STEPS];
	logic [31:0]          cz_s    [0:CORDIC_STEPS];
	logic                 cspec_s [0:CORDIC_STEPS];
	side_t                cside_s [0:CORDIC_STEPS];
	logic                 cvld_s  [0:CORDIC_STEPS];

	logic signed [16:0] xe, ye;
	logic [31:0]        z0;
	logic               spec0;

	always_comb begin
		xe    = {x_pos[15], x_pos};
		ye    = {y_pos[15], y_pos};
		z0    = 32'h0;
		spec0 = 1'b0;
		if (ye == 17'sd0) begin
			spec0 = 1'b1;
			z0    = (xe < 17'sd0) ? 32'h8000_0000 : 32'h0;
		end else if (xe == 17'sd0) begin
			spec0 = 1'b1;
			z0    = (ye > 17'sd0) ? 32'h4000_0000 : 32'hC000_0000;
		end else if (xe < 17'sd0) begin
			xe = -xe;
			ye = -ye;
			z0 = 32'h8000_0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_s[0] <= 1'b0;
		end else if (en) begin
			cvld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]    <= {{(CW-41){xe[16]}}, xe, 24'h0};
			cy_s[0]    <= {{(CW-41){ye[16]}}, ye, 24'h0};
			cz_s[0]    <= z0;
			cspec_s[0] <= spec0;
			cside_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx, dy;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[i+1] <= 1'b0;
			end else if (en) begin
				cvld_s[i+1] <= cvld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cspec_s[i+1] <= cspec_s[i];
				cside_s[i+1] <= cside_s[i];
				if (cy_s[i] > 0) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cspec_s[i] ? cz_s[i] : cz_s[i] + ATAN_TURN[i];
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cspec_s[i] ? cz_s[i] : cz_s[i] - ATAN_TURN[i];
				end
			end
		end
	end

	assign out_vld  = cvld_s[CORDIC_STEPS];
	assign out_side = cside_s[CORDIC_STEPS];
	assign out_z    = cz_s[CORDIC_STEPS];

endmodule

@@ rtl/lpai_rem.sv @@
// ----------------------------------------------------------------------------
// lpai_rem: pipelined restoring remainder by the sector count
// One dividend bit per stage; the remainder stays below the divisor.
// ----------------------------------------------------------------------------
module lpai_rem import lpai_pkg::*; #(
	parameter int SW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic          in_err,
	input  logic [15:0]   dividend,
	input  logic [SW-1:0] divisor,
	output logic          out_vld,
	output logic          out_err,
	output logic [SW-1:0] out_rem
);

	logic [SW-1:0]    r_s   [0:DIV_W];
	logic [DIV_W-1:0] dd_s  [0:DIV_W];
	logic             err_s [0:DIV_W];
	logic             vld_s [0:DIV_W];

	assign r_s[0]   = '0;
	assign dd_s[0]  = dividend;
	assign err_s[0] = in_err;
	assign vld_s[0] = in_vld;

	for (genvar j = 0; j < DIV_W; j++) begin : g_bit
		logic [SW:0] t, tn;

		always_comb begin
			t  = {r_s[j], dd_s[j][DIV_W-1-j]};
			tn = (t >= {1'b0, divisor}) ? t - {1'b0, divisor} : t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j+1]   <= tn[SW-1:0];
				dd_s[j+1]  <= dd_s[j];
				err_s[j+1] <= err_s[j];
			end
		end
	end

	assign out_vld = vld_s[DIV_W];
	assign out_err = err_s[DIV_W];
	assign out_rem = r_s[DIV_W];

endmodule

@@ rtl/logpolar_angle_index_top.sv @@
// ----------------------------------------------------------------------------
// logpolar_angle_index_top: angular sector of a point in a log-polar image
//
//   channel  dir  contents
//   cfg      in   register index, write data
//   req      in   cmd, x_pos, y_pos, ring, table_addr, table_data
//   rsp      out  sector, range_error (compute commands only)
//
// One word is taken per cycle while rsp is not stalled. The path has 49
// register stages, the first loaded at the edge that takes the word: 29
// CORDIC stages, the shift table read, three sector stages with the
// pad-map read, and 16 remainder stages. The whole pipeline holds while a
// result waits at rsp. Reset sets the configuration to its defaults and
// clears the valid bits; both tables keep whatever they held.
// ----------------------------------------------------------------------------
module logpolar_angle_index_top import lpai_pkg::*; #(
	parameter int MAX_RINGS   = DEF_MAX_RINGS,
	parameter int MAX_SECTORS = DEF_MAX_SECTORS,
	parameter int MAX_FOVEA   = DEF_MAX_FOVEA,
	parameter int ANGLE_BITS  = DEF_ANGLE_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	lpai_cfg_if.sink   cfg,
	lpai_req_if.sink   req,
	lpai_rsp_if.source rsp
);

	localparam int SW  = $clog2(MAX_SECTORS + 1);
	localparam int RW  = $clog2(MAX_RINGS);
	localparam int FW  = $clog2(MAX_FOVEA + 1);
	localparam int AB  = ANGLE_BITS;
	localparam int EPS = ((1 << AB) + 50) / 100;
	localparam int RND = 1 << (31 - AB);
	localparam int PW  = AB + SW + 1;
	localparam int MW  = AB + 11;
	localparam int IW  = SW + 9;

	logic          en;
	logic [8:0]    sectors_q;
	logic [6:0]    fovea_q;
	logic [1:0]    mode_q;
	logic [SW-1:0] s_eff;
	logic [FW-1:0] f_eff;

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sectors_q <= 9'd252;
			fovea_q   <= 7'd42;
			mode_q    <= MODE_PAD;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SECTORS: sectors_q <= cfg.data;
				REG_FOVEA:   fovea_q   <= cfg.data[6:0];
				REG_MODE:    mode_q    <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sectors_q == 9'd0) begin
			s_eff = SW'(1);
		end else if (32'(sectors_q) > MAX_SECTORS) begin
			s_eff = SW'(MAX_SECTORS);
		end else begin
			s_eff = SW'(sectors_q);
		end
		if (32'(fovea_q) > MAX_FOVEA) begin
			f_eff = FW'(MAX_FOVEA);
		end else begin
			f_eff = FW'(fovea_q);
		end
	end

	side_t       in_side;
	logic        c_vld;
	side_t       c_side;
	logic [31:0] c_z;

	assign in_side = '{cmd: req.cmd, ring: req.ring, addr: req.table_addr,
		data: req.table_data};

	lpai_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (req.valid),
		.in_side  (in_side),
		.x_pos    (req.x_pos),
		.y_pos    (req.y_pos),
		.out_vld  (c_vld),
		.out_side (c_side),
		.out_z    (c_z)
	);

	// Shift table: reads and writes both happen at this stage, in word order.
	logic [15:0] shift_mem [MAX_RINGS];
	logic [15:0] sh_rd_q;
	logic        ring_ok;

	assign ring_ok = 32'(c_side.ring) < MAX_RINGS;

	always_ff @(posedge clk) begin
		if (en) begin
			if (c_vld && c_side.cmd == CMD_SHIFT && ring_ok) begin
				shift_mem[RW'(c_side.ring)] <= c_side.data;
			end
			sh_rd_q <= shift_mem[RW'(c_side.ring)];
		end
	end

	logic        vld_s1, shok_s1;
	side_t       side_s1;
	logic [31:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= c_side;
			z_s1    <= c_z;
			shok_s1 <= ring_ok;
		end
	end

	logic [15:0] shv;
	logic [31:0] dz, dr;
	logic        fov;
	kind_t       kind_c;
	logic [10:0] m_c;

	always_comb begin
		shv = shok_s1 ? sh_rd_q : 16'h0;
		dz  = z_s1 - {shv, 16'h0};
		dr  = dz + 32'(RND);
		fov = 32'(side_s1.ring) < 32'(f_eff);
		if (fov && mode_q == MODE_PAD) begin
			kind_c = K_PAD;
		end else if (fov && mode_q == MODE_GROW) begin
			kind_c = K_GROW;
		end else begin
			kind_c = K_UNI;
		end
		m_c = (side_s1.ring == 8'd0) ? 11'd1 : 11'(side_s1.ring) * 11'd6;
	end

	logic          vld_s2;
	side_t         side_s2;
	logic [AB-1:0] a_s2;
	kind_t         kind_s2;
	logic [10:0]   m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			a_s2    <= dr[31 -: AB];
			kind_s2 <= kind_c;
			m_s2    <= m_c;
		end
	end

	logic          vld_s3;
	side_t         side_s3;
	kind_t         kind_s3;
	logic [PW-1:0] pu_s3;
	logic [MW-1:0] pm_s3;
	logic [IW-1:0] sr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			kind_s3 <= kind_s2;
			pu_s3   <= PW'(a_s2) * PW'(s_eff) + PW'(EPS);
			pm_s3   <= MW'(a_s2) * MW'(m_s2) + MW'(EPS);
			sr_s3   <= IW'(s_eff) * IW'(side_s2.ring);
		end
	end

	logic [IW-1:0] idx;
	logic          err_c;

	assign idx   = IW'(pm_s3[MW-1:AB]) + sr_s3;
	assign err_c = (kind_s3 == K_PAD) && (32'(idx) >= PAD_DEPTH);

	// Pad map: reads and writes both happen at this stage, in word order.
	logic [15:0] pad_mem [PAD_DEPTH];
	logic [15:0] pad_rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (vld_s3 && side_s3.cmd == CMD_PAD) begin
				pad_mem[side_s3.addr] <= side_s3.data;
			end
			pad_rd_q <= pad_mem[idx[PAD_AW-1:0]];
		end
	end

	logic        vld_s4, err_s4;
	logic [1:0]  cmd_s4;
	kind_t       kind_s4;
	logic [SW:0] q_s4;
	logic [10:0] vm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4  <= side_s3.cmd;
			kind_s4 <= kind_s3;
			q_s4    <= pu_s3[PW-1:AB];
			vm_s4   <= pm_s3[MW-1:AB];
			err_s4  <= err_c;
		end
	end

	logic [15:0]   dividend;
	logic          rem_vld, rem_err;
	logic [SW-1:0] rem_out;

	always_comb begin
		case (kind_s4)
			K_UNI:   dividend = 16'(q_s4);
			K_GROW:  dividend = 16'(vm_s4);
			K_PAD:   dividend = err_s4 ? 16'h0 : pad_rd_q;
			default: dividend = 16'h0;
		endcase
	end

	lpai_rem #(.SW(SW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4 && cmd_s4 == CMD_CALC),
		.in_err   (err_s4),
		.dividend (dividend),
		.divisor  (s_eff),
		.out_vld  (rem_vld),
		.out_err  (rem_err),
		.out_rem  (rem_out)
	);

	assign rsp.valid       = rem_vld;
	assign rsp.sector      = 8'(rem_out);
	assign rsp.range_error = rem_err;

	a_sector_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rem_out < s_eff)
		else $error("sector index not below the sector count");

	a_error_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_error |-> rsp.sector == 8'd0)
		else $error("range error with a nonzero sector");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s4) && $stable(sh_rd_q))
		else $error("pipeline moved while the result word was stalled");

endmodule
